// ----- rtl/ptq_pkg.sv -----
// ----------------------------------------------------------------------------
// ptq_pkg: shared types for the process table queue
// Transaction structs, entry layout, action and status codes, control bundles.
// ----------------------------------------------------------------------------
package ptq_pkg;

	localparam int unsigned DEPTH_DEF = 16;

	typedef enum logic [2:0] {
		ACT_PUSH    = 3'd0,
		ACT_POP     = 3'd1,
		ACT_EXTRACT = 3'd2,
		ACT_READ    = 3'd3,
		ACT_MAXPRIO = 3'd4,
		ACT_SORT    = 3'd5,
		ACT_CLEAR   = 3'd6,
		ACT_NOP     = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_INDEX = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] arrival_time;
		logic [15:0] burst_time;
		logic [7:0]  priority_level;
		logic [15:0] used_time;
		logic [7:0]  process_id;
		logic [3:0]  index;
	} ptq_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_arrival;
		logic [15:0] out_burst;
		logic [7:0]  out_priority;
		logic [15:0] out_used;
		logic [7:0]  out_id;
		logic [4:0]  entry_total;
		logic [7:0]  max_priority;
	} ptq_out_t;

	typedef struct packed {
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [7:0]  prio;
		logic [15:0] used;
		logic [7:0]  id;
	} entry_t;

	typedef enum logic [1:0] {RA_I, RA_I1, RA_JM1, RA_BEST} rd_sel_t;
	typedef enum logic [1:0] {WA_COUNT, WA_I, WA_J} wa_sel_t;
	typedef enum logic [1:0] {WD_IN, WD_RDATA, WD_TMP} wd_sel_t;
	typedef enum logic [2:0] {I_HOLD, I_ZERO, I_ONE, I_INC, I_BEST} i_op_t;

	typedef struct packed {
		logic    load;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wa_sel_t wa_sel;
		wd_sel_t wd_sel;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    cnt_clr;
		i_op_t   i_op;
		logic    j_load;
		logic    j_dec;
		logic    best_upd;
		logic    best_zero;
		logic    best_idx;
		logic    tmp_load;
		logic    max_clr;
		logic    max_upd;
		logic    res_load;
		logic    st_wr;
		status_t st_val;
	} ptq_cmd_t;

	typedef struct packed {
		action_t action;
		logic    empty;
		logic    full;
		logic    idx_bad;
		logic    i_lt_cnt;
		logic    i1_lt_cnt;
		logic    j_zero;
		logic    id_gt;
	} ptq_stat_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CMP, S_OUT_RD, S_OUT_WAIT,
		S_SHIFT_RD, S_SHIFT_WR, S_SORT_I, S_SORT_TMP, S_SORT_RD, S_SORT_CMP,
		S_MAX_INIT, S_MAX_RD, S_MAX_CMP, S_DONE
	} ctl_state_t;

endpackage

// ----- rtl/ptq_datapath.sv -----
// ----------------------------------------------------------------------------
// ptq_datapath: entry memory, walk counters and result registers
// Executes one memory read and one memory write per cycle under command.
// ----------------------------------------------------------------------------
module ptq_datapath import ptq_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ptq_in_t   req,
	input  ptq_cmd_t  cmd,
	output ptq_stat_t stat,
	output ptq_out_t  rsp
);

	localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW   = $clog2(DEPTH + 1);
	localparam int unsigned CMPW = (CW > 4) ? CW : 4;

	entry_t          mem [DEPTH];
	entry_t          rdata_q;
	entry_t          tmp_q;
	ptq_in_t         in_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   i_q;
	logic [CW-1:0]   j_q;
	logic [IW-1:0]   best_q;
	logic [15:0]     best_arr_q;
	logic [7:0]      maxp_q;
	status_t         st_q;
	entry_t          res_q;

	logic [CW:0]     i_inc1;
	logic [CW-1:0]   j_m1;
	logic [IW-1:0]   rd_addr;
	logic [IW-1:0]   wr_addr;
	entry_t          wr_data;
	entry_t          in_entry;

	assign i_inc1 = {1'b0, i_q} + 1'b1;
	assign j_m1   = j_q - 1'b1;
	assign in_entry = '{arrival: in_q.arrival_time, burst: in_q.burst_time,
		prio: in_q.priority_level, used: in_q.used_time, id: in_q.process_id};

	always_comb begin
		unique case (cmd.rd_sel)
			RA_I:    rd_addr = i_q[IW-1:0];
			RA_I1:   rd_addr = i_inc1[IW-1:0];
			RA_JM1:  rd_addr = j_m1[IW-1:0];
			RA_BEST: rd_addr = best_q;
			default: rd_addr = i_q[IW-1:0];
		endcase
		unique case (cmd.wa_sel)
			WA_COUNT: wr_addr = count_q[IW-1:0];
			WA_I:     wr_addr = i_q[IW-1:0];
			WA_J:     wr_addr = j_q[IW-1:0];
			default:  wr_addr = i_q[IW-1:0];
		endcase
		unique case (cmd.wd_sel)
			WD_IN:    wr_data = in_entry;
			WD_RDATA: wr_data = rdata_q;
			WD_TMP:   wr_data = tmp_q;
			default:  wr_data = rdata_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		if (cmd.load) begin
			in_q <= req;
		end
		if (cmd.tmp_load) begin
			tmp_q <= rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			i_q        <= '0;
			j_q        <= '0;
			best_q     <= '0;
			best_arr_q <= '0;
			maxp_q     <= '0;
			st_q       <= ST_OK;
			res_q      <= '0;
		end else begin
			if (cmd.cnt_clr) begin
				count_q <= '0;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
			unique case (cmd.i_op)
				I_HOLD:  i_q <= i_q;
				I_ZERO:  i_q <= '0;
				I_ONE:   i_q <= CW'(1);
				I_INC:   i_q <= i_inc1[CW-1:0];
				I_BEST:  i_q <= CW'(best_q);
				default: i_q <= i_q;
			endcase
			if (cmd.j_load) begin
				j_q <= i_q;
			end else if (cmd.j_dec) begin
				j_q <= j_m1;
			end
			if (cmd.best_zero) begin
				best_q <= '0;
			end else if (cmd.best_idx) begin
				best_q <= IW'(in_q.index);
			end else if (cmd.best_upd && (i_q == '0 || rdata_q.arrival < best_arr_q)) begin
				best_q     <= i_q[IW-1:0];
				best_arr_q <= rdata_q.arrival;
			end
			if (cmd.max_clr) begin
				maxp_q <= '0;
			end else if (cmd.max_upd && rdata_q.prio > maxp_q) begin
				maxp_q <= rdata_q.prio;
			end
			if (cmd.load) begin
				st_q  <= ST_OK;
				res_q <= '0;
			end else begin
				if (cmd.st_wr) begin
					st_q <= cmd.st_val;
				end
				if (cmd.res_load) begin
					res_q <= rdata_q;
				end
			end
		end
	end

	assign stat.action    = action_t'(in_q.action);
	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q >= CW'(DEPTH));
	assign stat.idx_bad   = (CMPW'(in_q.index) >= CMPW'(count_q));
	assign stat.i_lt_cnt  = (i_q < count_q);
	assign stat.i1_lt_cnt = (i_inc1 < {1'b0, count_q});
	assign stat.j_zero    = (j_q == '0);
	assign stat.id_gt     = (rdata_q.id > tmp_q.id);

	assign rsp.status       = st_q;
	assign rsp.out_arrival  = res_q.arrival;
	assign rsp.out_burst    = res_q.burst;
	assign rsp.out_priority = res_q.prio;
	assign rsp.out_used     = res_q.used;
	assign rsp.out_id       = res_q.id;
	assign rsp.entry_total  = 5'(count_q);
	assign rsp.max_priority = maxp_q;

endmodule

// ----- rtl/ptq_controller.sv -----
// ----------------------------------------------------------------------------
// ptq_controller: action sequencer
// Sequences each action, walking the entry memory where the action needs it,
// and closes every action with a priority scan.
module ptq_controller import ptq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  ptq_stat_t stat,
	output ptq_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (start) state_d = S_DISPATCH;
			S_DISPATCH: begin
				unique case (stat.action)
					ACT_POP:     state_d = stat.empty ? S_MAX_INIT : S_OUT_RD;
					ACT_EXTRACT: state_d = stat.empty ? S_MAX_INIT : S_SCAN_RD;
					ACT_READ:    state_d = stat.idx_bad ? S_MAX_INIT : S_OUT_RD;
					ACT_SORT:    state_d = S_SORT_I;
					default:     state_d = S_MAX_INIT;
				endcase
			end
			S_SCAN_RD:  state_d = S_SCAN_CMP;
			S_SCAN_CMP: state_d = stat.i1_lt_cnt ? S_SCAN_RD : S_OUT_RD;
			S_OUT_RD:   state_d = S_OUT_WAIT;
			S_OUT_WAIT: state_d = (stat.action == ACT_READ) ? S_MAX_INIT : S_SHIFT_RD;
			S_SHIFT_RD: state_d = stat.i1_lt_cnt ? S_SHIFT_WR : S_MAX_INIT;
			S_SHIFT_WR: state_d = S_SHIFT_RD;
			S_SORT_I:   state_d = stat.i_lt_cnt ? S_SORT_TMP : S_MAX_INIT;
			S_SORT_TMP: state_d = S_SORT_RD;
			S_SORT_RD:  state_d = stat.j_zero ? S_SORT_I : S_SORT_CMP;
			S_SORT_CMP: state_d = stat.id_gt ? S_SORT_RD : S_SORT_I;
			S_MAX_INIT: state_d = S_MAX_RD;
			S_MAX_RD:   state_d = stat.i_lt_cnt ? S_MAX_CMP : S_DONE;
			S_MAX_CMP:  state_d = S_MAX_RD;
			S_DONE:     state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = RA_I;
		cmd.wa_sel = WA_I;
		cmd.wd_sel = WD_RDATA;
		cmd.i_op   = I_HOLD;
		cmd.st_val = ST_OK;
		unique case (state_q)
			S_IDLE:     cmd.load = start;
			S_DISPATCH: begin
				unique case (stat.action)
					ACT_PUSH: begin
						if (stat.full) begin
							cmd.st_wr  = 1'b1;
							cmd.st_val = ST_FULL;
						end else begin
							cmd.wr_en   = 1'b1;
							cmd.wa_sel  = WA_COUNT;
							cmd.wd_sel  = WD_IN;
							cmd.cnt_inc = 1'b1;
						end
					end
					ACT_POP: begin
						cmd.st_wr     = stat.empty;
						cmd.st_val    = ST_EMPTY;
						cmd.best_zero = 1'b1;
					end
					ACT_EXTRACT: begin
						cmd.st_wr  = stat.empty;
						cmd.st_val = ST_EMPTY;
						cmd.i_op   = I_ZERO;
					end
					ACT_READ: begin
						cmd.st_wr    = stat.idx_bad;
						cmd.st_val   = ST_INDEX;
						cmd.best_idx = 1'b1;
					end
					ACT_MAXPRIO: begin
						cmd.st_wr  = stat.empty;
						cmd.st_val = ST_EMPTY;
					end
					ACT_SORT:  cmd.i_op = I_ONE;
					ACT_CLEAR: cmd.cnt_clr = 1'b1;
					default:   cmd.st_wr = 1'b0;
				endcase
			end
			S_SCAN_RD:  cmd.rd_en = 1'b1;
			S_SCAN_CMP: begin
				cmd.best_upd = 1'b1;
				cmd.i_op     = I_INC;
			end
			S_OUT_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RA_BEST;
			end
			S_OUT_WAIT: begin
				cmd.res_load = 1'b1;
				cmd.i_op     = I_BEST;
			end
			S_SHIFT_RD: begin
				cmd.rd_en   = stat.i1_lt_cnt;
				cmd.rd_sel  = RA_I1;
				cmd.cnt_dec = !stat.i1_lt_cnt;
			end
			S_SHIFT_WR: begin
				cmd.wr_en = 1'b1;
				cmd.i_op  = I_INC;
			end
			S_SORT_I:   cmd.rd_en = stat.i_lt_cnt;
			S_SORT_TMP: begin
				cmd.tmp_load = 1'b1;
				cmd.j_load   = 1'b1;
			end
			S_SORT_RD: begin
				if (stat.j_zero) begin
					cmd.wr_en  = 1'b1;
					cmd.wa_sel = WA_J;
					cmd.wd_sel = WD_TMP;
					cmd.i_op   = I_INC;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_JM1;
				end
			end
			S_SORT_CMP: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = WA_J;
				if (stat.id_gt) begin
					cmd.wd_sel = WD_RDATA;
					cmd.j_dec  = 1'b1;
				end else begin
					cmd.wd_sel = WD_TMP;
					cmd.i_op   = I_INC;
				end
			end
			S_MAX_INIT: begin
				cmd.max_clr = 1'b1;
				cmd.i_op    = I_ZERO;
			end
			S_MAX_RD:   cmd.rd_en = stat.i_lt_cnt;
			S_MAX_CMP: begin
				cmd.max_upd = 1'b1;
				cmd.i_op    = I_INC;
			end
			S_DONE:     cmd.load = 1'b0;
			default:    cmd.load = 1'b0;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

// ----- rtl/process_table_queue.sv -----
// ----------------------------------------------------------------------------
// process_table_queue: ordered table of process descriptors
// Push, pop, extract-earliest, read, max-priority, sort-by-id and clear on a
// table of up to DEPTH entries held in a single-port-read memory.
//
// Usage: present a request transaction on req and raise start while busy is
// low; the transaction is taken at that clock edge and busy rises. One result
// transaction follows on rsp, marked by done for exactly one cycle; busy
// falls in the cycle after done. The receiver cannot stall: rsp is valid only
// while done is high.
// Each action ends with a priority scan of the entries left after the action.
// Read fetches the entry at the given index. Pop fetches the first entry and
// extract the earliest-arriving one, found by a scan; both then shift the later
// entries down. Sort runs insertion passes by id. One transaction is in flight
// at a time.
// Reset: the table is empty and the block idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
module process_table_queue import ptq_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  ptq_in_t  req,
	output logic     done,
	output ptq_out_t rsp
);

	ptq_cmd_t  cmd;
	ptq_stat_t stat;

	ptq_controller u_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ptq_datapath #(.DEPTH(DEPTH)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

// ----- rtl/ptq_checker.sv -----
// ----------------------------------------------------------------------------
// ptq_checker: port-level checks for the process table queue
// Observes the command handshake and result strobe over time.
// ----------------------------------------------------------------------------
module ptq_checker import ptq_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input ptq_in_t  req,
	input logic     done,
	input ptq_out_t rsp
);

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transaction taken without busy");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_OK |-> rsp.out_arrival == '0 && rsp.out_burst == '0
			&& rsp.out_priority == '0 && rsp.out_used == '0 && rsp.out_id == '0)
		else $error("entry fields nonzero on failed transaction");

	a_no_req_use: assert property (@(posedge clk) disable iff (!arst_n)
		done && req.action == req.action |-> !$past(done))
		else $error("back-to-back result strobes");

endmodule

bind process_table_queue ptq_checker u_chk (.*);
